[sv/assert_macros.svh]
// Shared assertion macros for the pair difference counter checks.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pdc assertion failed");

// Next-cycle implication.
`define PDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pdc assertion failed");

`endif

[sv/pdc_pkg.sv]
package pdc_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned TARGET_W      = VALUE_W + 1;
  localparam int unsigned CNT_W         = 11;
  localparam int unsigned MAX_ITEMS_DEF = 1024;
  localparam logic [CNT_W-1:0] COUNT_SAT = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_INIT,
    ST_SEARCH,
    ST_DRAIN
  } pdc_state_e;

  // Control broadcast to every cell
  typedef struct packed {
    logic load;     // shift a new value into the row
    logic init;     // build probes from stored values
    logic rotate;   // move probes one cell along the ring
    logic compare;  // match incoming probes against stored values
  } cell_ctrl_t;

  // Probe token travelling around the ring
  typedef struct packed {
    logic                       vld;
    logic                       found;
    logic signed [TARGET_W-1:0] target;
  } probe_t;

endpackage

[sv/pdc_in_if.sv]
interface pdc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pdc_pkg::VALUE_W-1:0]   value;
  logic                                 last_value;

  modport source (output valid, value, last_value, input ready);
  modport sink   (input valid, value, last_value, output ready);
endinterface

[sv/pdc_out_if.sv]
interface pdc_out_if;
  logic                             valid;
  logic                             ready;
  logic [pdc_pkg::CNT_W-1:0]        pair_count;
  logic                             overflowed;

  modport source (output valid, pair_count, overflowed, input ready);
  modport sink   (input valid, pair_count, overflowed, output ready);
endinterface

[sv/pdc_cell.sv]
module pdc_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pdc_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [pdc_pkg::VALUE_W-1:0] k_diff_i,
  input  logic                               valid_i,
  input  logic signed [pdc_pkg::VALUE_W-1:0] value_i,
  output logic signed [pdc_pkg::VALUE_W-1:0] value_o,
  input  pdc_pkg::probe_t                    probe_i,
  output pdc_pkg::probe_t                    probe_o
);
  import pdc_pkg::*;

  logic signed [VALUE_W-1:0]  stored_q, stored_d;
  logic signed [TARGET_W-1:0] stored_ext;
  logic signed [TARGET_W-1:0] k_ext;
  logic                       hit;
  probe_t                     probe_q, probe_d;

  assign stored_ext = {stored_q[VALUE_W-1], stored_q};
  assign k_ext      = {k_diff_i[VALUE_W-1], k_diff_i};

  // incoming probe hits when this cell holds its target
  assign hit = ctrl_i.compare & probe_i.vld & valid_i & (stored_ext == probe_i.target);

  // value row: shifts on each loaded transfer
  always_comb begin
    stored_d = ctrl_i.load ? value_i : stored_q;
  end

  always_ff @(posedge clk_i) begin
    stored_q <= stored_d;
  end

  // probe stage
  always_comb begin
    probe_d = probe_q;
    if (ctrl_i.init) begin
      probe_d.vld    = valid_i;
      probe_d.found  = 1'b0;
      probe_d.target = stored_ext + k_ext;
    end else if (ctrl_i.rotate) begin
      probe_d.vld    = probe_i.vld;
      probe_d.found  = probe_i.found | hit;
      probe_d.target = probe_i.target;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign value_o = stored_q;
  assign probe_o = probe_q;

endmodule

[sv/pair_difference_counter_core.sv]
// Loading: one value per cycle; a value may follow in every cycle.
// After the transfer that carries last_value the input is closed and the result is valid
// after one probe build, MAX_ITEMS-1 ring steps and MAX_ITEMS drain steps; the probe ring
// walks once around the row of cells and once more to be counted.
// A result waiting at the output holds the final drain step until it is taken.
// Reset clears state, fill count, overflow flag and k_diff; stored values are not reset.
module pair_difference_counter_core #(
  parameter int unsigned MAX_ITEMS = pdc_pkg::MAX_ITEMS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               k_diff_we_i,
  input  logic signed [pdc_pkg::VALUE_W-1:0] k_diff_i,
  pdc_in_if.sink                             in_i,
  pdc_out_if.source                          out_o
);
  import pdc_pkg::*;

  localparam int unsigned NW = $clog2(MAX_ITEMS + 1);

  pdc_state_e                state_q, state_d;
  logic [NW-1:0]             n_q, n_d;
  logic [NW-1:0]             step_q, step_d;
  logic                      ovf_q, ovf_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [CNT_W-1:0]          cnt_add;
  logic signed [VALUE_W-1:0] k_q;
  logic                      out_vld_q, out_vld_d;
  logic [CNT_W-1:0]          out_cnt_q, out_cnt_d;
  logic                      out_ovf_q, out_ovf_d;
  logic                      in_xfer;
  logic                      last_step;
  cell_ctrl_t                ctrl;

  logic signed [VALUE_W-1:0] value_w [MAX_ITEMS];
  probe_t                    probe_w [MAX_ITEMS];

  // difference register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (k_diff_we_i) begin
      k_q <= k_diff_i;
    end
  end

  // row of cells closed into a ring for the probes
  for (genvar c = 0; c < MAX_ITEMS; c++) begin : g_cell
    logic                      cell_vld;
    logic signed [VALUE_W-1:0] val_in;
    probe_t                    prb_in;

    assign cell_vld = (NW'(c) < n_q);

    if (c == 0) begin : g_head
      assign val_in = in_i.value;
      assign prb_in = probe_w[MAX_ITEMS-1];
    end else begin : g_body
      assign val_in = value_w[c-1];
      assign prb_in = probe_w[c-1];
    end

    pdc_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .k_diff_i (k_q),
      .valid_i  (cell_vld),
      .value_i  (val_in),
      .value_o  (value_w[c]),
      .probe_i  (prb_in),
      .probe_o  (probe_w[c])
    );
  end

  assign in_xfer   = in_i.valid & in_i.ready;
  assign last_step = (step_q == NW'(MAX_ITEMS - 1));
  assign cnt_add   = (probe_w[MAX_ITEMS-1].found && (cnt_q != COUNT_SAT)) ? cnt_q + 1'b1 : cnt_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    ovf_d     = ovf_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    ctrl      = '0;
    out_vld_d = out_vld_q & ~out_o.ready;
    out_cnt_d = out_cnt_q;
    out_ovf_d = out_ovf_q;

    case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          if (n_q < NW'(MAX_ITEMS)) begin
            ctrl.load = 1'b1;
            n_d       = n_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last_value) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        ctrl.init = 1'b1;
        step_d    = '0;
        cnt_d     = '0;
        state_d   = ST_SEARCH;
      end
      ST_SEARCH: begin
        ctrl.rotate  = 1'b1;
        ctrl.compare = 1'b1;
        if (step_q == NW'(MAX_ITEMS - 2)) begin
          step_d  = '0;
          state_d = ST_DRAIN;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // hold the last step while an older result is still pending
        if (!(last_step && out_vld_q && !out_o.ready)) begin
          ctrl.rotate = 1'b1;
          cnt_d       = cnt_add;
          if (last_step) begin
            out_vld_d = 1'b1;
            out_cnt_d = cnt_add;
            out_ovf_d = ovf_q;
            n_d       = '0;
            ovf_d     = 1'b0;
            step_d    = '0;
            state_d   = ST_LOAD;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      n_q       <= '0;
      ovf_q     <= 1'b0;
      step_q    <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      ovf_q     <= ovf_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_cnt_q <= out_cnt_d;
    out_ovf_q <= out_ovf_d;
  end

  assign in_i.ready       = (state_q == ST_LOAD);
  assign out_o.valid      = out_vld_q;
  assign out_o.pair_count = out_cnt_q;
  assign out_o.overflowed = out_ovf_q;

endmodule

[sv/pdc_checker.sv]
`include "assert_macros.svh"

module pdc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_last_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [pdc_pkg::CNT_W-1:0] out_count_i,
  input logic                      out_ovf_i
);

  // a pending result keeps its valid
  `PDC_ASSERT_NEXT(a_out_hold_valid, out_valid_i && !out_ready_i, out_valid_i)

  // a pending result keeps its payload
  `PDC_ASSERT_NEXT(a_out_hold_data, out_valid_i && !out_ready_i, $stable(out_count_i) && $stable(out_ovf_i))

  // the set stays closed after its final transfer, through the probe build and into the search
  `PDC_ASSERT_NEXT(a_busy_after_last, in_valid_i && in_ready_i && in_last_i, !in_ready_i ##1 !in_ready_i)

  // input reopens only together with a fresh result
  `PDC_ASSERT_NOW(a_reopen_with_result, $rose(in_ready_i), out_valid_i)

endmodule

bind pair_difference_counter_core pdc_checker u_pdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_value),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_count_i (out_o.pair_count),
  .out_ovf_i   (out_o.overflowed)
);

[sim/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = pdc_pkg::MAX_ITEMS_DEF;
  localparam int unsigned ITEM_GOAL   = 1330;
  localparam int unsigned SET_GOAL    = 40;
  localparam int unsigned HOLD_CYCLES = 6000;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  localparam logic signed [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef enum logic {ROW_ITEM, ROW_K} row_kind_e;

  // One directed row: an item to send, or a new k_diff
  typedef struct packed {
    row_kind_e                     kind;
    logic signed [31:0]            value;
    logic                          is_last;
    logic                          typed;
    logic [pdc_pkg::CNT_W-1:0]     pair_count;
    logic                          overflowed;
  } dir_row_t;

  typedef struct packed {
    logic [pdc_pkg::CNT_W-1:0] pair_count;
    logic                      overflowed;
  } pdc_result_t;

  // Directed sets: duplicates at k=0, single value, extremes at k=1, max and min, then k=-3
  localparam dir_row_t DIR_TABLE [24] = '{
    '{ROW_ITEM, 32'sd5,             1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 32'sd5,             1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 32'sd7,             1'b1, 1'b1, 11'd2, 1'b0},
    '{ROW_ITEM, 32'sd0,             1'b1, 1'b1, 11'd0, 1'b0},
    '{ROW_K,    32'sd1,             1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, VAL_MIN,            1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, VAL_MIN + 32'sd1,   1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, VAL_MAX,            1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, VAL_MAX - 32'sd1,   1'b1, 1'b1, 11'd2, 1'b0},
    '{ROW_K,    VAL_MAX,            1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, VAL_MIN,            1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, -32'sd1,            1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 32'sd0,             1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, VAL_MAX,            1'b1, 1'b1, 11'd2, 1'b0},
    '{ROW_K,    VAL_MIN,            1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, VAL_MAX,            1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, -32'sd1,            1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 32'sd0,             1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, VAL_MIN,            1'b1, 1'b1, 11'd2, 1'b0},
    '{ROW_K,    -32'sd3,            1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 32'sd10,            1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 32'sd7,             1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 32'sd4,             1'b0, 1'b0, 11'd0, 1'b0},
    '{ROW_ITEM, 32'sd4,             1'b1, 1'b0, 11'd0, 1'b0}
  };

  logic                               clk_i;
  logic                               rst_ni;
  logic                               k_diff_we;
  logic signed [pdc_pkg::VALUE_W-1:0] k_diff_val;

  pdc_in_if  in_if ();
  pdc_out_if out_if ();

  pair_difference_counter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .k_diff_we_i (k_diff_we),
    .k_diff_i    (k_diff_val),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Mirror of the block state
  logic signed [31:0] mirror_store [STORE_DEPTH];
  int unsigned        mirror_fill;
  logic               mirror_ovf;
  logic signed [31:0] mirror_k;

  pdc_result_t pending_counts [$];
  pdc_result_t head;

  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned items_sent;
  int unsigned sets_done;
  int unsigned ovf_sets;
  int unsigned k_writes;
  bit          pressure_done;

  // Elements whose value plus k (33-bit sum) occurs at another element
  function automatic logic [pdc_pkg::CNT_W-1:0] count_matching_pairs();
    int unsigned                         hits;
    logic signed [pdc_pkg::TARGET_W-1:0] target;
    bit                                  found;
    hits = 0;
    for (int unsigned i = 0; i < mirror_fill; i++) begin
      target = mirror_store[i] + mirror_k;
      found  = 1'b0;
      for (int unsigned j = 0; j < mirror_fill && !found; j++) begin
        if (j != i && mirror_store[j] == target) found = 1'b1;
      end
      if (found && hits < pdc_pkg::COUNT_SAT) hits++;
    end
    return hits[pdc_pkg::CNT_W-1:0];
  endfunction

  // Load one value; returns 1 with the count when the set closes
  function automatic bit mirror_load(input logic signed [31:0] v, input logic is_last,
                                     output pdc_result_t r);
    r = '0;
    if (mirror_fill < STORE_DEPTH) begin
      mirror_store[mirror_fill] = v;
      mirror_fill++;
    end else begin
      mirror_ovf = 1'b1;
    end
    if (!is_last) return 1'b0;
    r.pair_count = count_matching_pairs();
    r.overflowed = mirror_ovf;
    mirror_fill  = 0;
    mirror_ovf   = 1'b0;
    return 1'b1;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Values chained by k, clustered near a base, extremes, or anything
  function automatic logic signed [31:0] random_value(input logic signed [31:0] base);
    logic signed [31:0] v;
    int unsigned        r;
    r = $urandom_range(0, 99);
    v = base;
    if (r < 45) begin
      repeat ($urandom_range(0, 3)) v = v + mirror_k;
    end else if (r < 65) begin
      v = base + 32'($urandom_range(0, 6)) - 32'd3;
    end else if (r < 80) begin
      case ($urandom_range(0, 6))
        0:       v = VAL_MIN;
        1:       v = VAL_MIN + 32'sd1;
        2:       v = -32'sd1;
        3:       v = 32'sd0;
        4:       v = 32'sd1;
        5:       v = VAL_MAX - 32'sd1;
        default: v = VAL_MAX;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i) cycle_count++;
    $display("run timed out after %0d cycles, %0d results outstanding",
             cycle_count, pending_counts.size());
    $display("FAIL");
    $finish;
  end

  // Result sink: random stalls, quiet stretches, one long hold-off
  initial begin
    int unsigned stall_left;
    bit          quiet;
    stall_left    = 0;
    quiet         = 1'b0;
    pressure_done = 1'b0;
    out_if.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 499) == 0) quiet = !quiet;
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!pressure_done && results_seen >= 8 && out_if.valid === 1'b1 &&
                   in_if.valid === 1'b1) begin
        // hold the result while the next set is offered
        pressure_done = 1'b1;
        stall_left    = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (quiet || $urandom_range(0, 99) < 75) begin
        out_if.ready <= 1'b1;
      end else begin
        stall_left    = gap_cycles() - 1;
        out_if.ready <= 1'b0;
      end
    end
  end

  // Result check against the oldest expected count
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      results_seen++;
      if (pending_counts.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result with nothing expected: pair_count %0d overflowed %0b",
                   $realtime, out_if.pair_count, out_if.overflowed);
      end else begin
        head = pending_counts.pop_front();
        if (out_if.pair_count !== head.pair_count || out_if.overflowed !== head.overflowed)
        begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result %0d: pair_count exp %0d got %0d, overflowed exp %0b got %0b",
                     $realtime, results_seen, head.pair_count, out_if.pair_count,
                     head.overflowed, out_if.overflowed);
        end
      end
    end
  end

  // Pause the input with valid held low
  task automatic pause(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
  endtask

  // Offer one value and wait for its transfer
  task automatic send_value(input logic signed [31:0] v, input logic is_last,
                            input logic typed, input logic [pdc_pkg::CNT_W-1:0] t_cnt,
                            input logic t_ovf);
    pdc_result_t r;
    @(negedge clk_i);
    in_if.valid      <= 1'b1;
    in_if.value      <= v;
    in_if.last_value <= is_last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    items_sent++;
    if (mirror_load(v, is_last, r)) begin
      if (typed) begin
        r.pair_count = t_cnt;
        r.overflowed = t_ovf;
      end
      pending_counts.push_back(r);
      sets_done++;
      if (r.overflowed) ovf_sets++;
    end
  endtask

  // New k_diff, only once the block has delivered every count
  task automatic set_k(input logic signed [31:0] v);
    pause(1);
    while (pending_counts.size() != 0) @(negedge clk_i);
    pause(4);
    @(negedge clk_i);
    k_diff_we  <= 1'b1;
    k_diff_val <= v;
    @(negedge clk_i);
    k_diff_we  <= 1'b0;
    mirror_k = v;
    k_writes++;
  endtask

  // Stimulus
  initial begin
    logic signed [31:0] base;
    logic signed [31:0] next_k;
    int unsigned        set_len;
    int unsigned        set_idx;
    bit                 quiet;

    rst_ni           = 1'b0;
    k_diff_we        = 1'b0;
    k_diff_val       = '0;
    in_if.valid      = 1'b0;
    in_if.value      = '0;
    in_if.last_value = 1'b0;
    mirror_fill      = 0;
    mirror_ovf       = 1'b0;
    mirror_k         = '0;
    fail_count       = 0;
    results_seen     = 0;
    items_sent       = 0;
    sets_done        = 0;
    ovf_sets         = 0;
    k_writes         = 0;

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // directed sets
    foreach (DIR_TABLE[r]) begin
      if (DIR_TABLE[r].kind == ROW_K) begin
        set_k(DIR_TABLE[r].value);
      end else begin
        send_value(DIR_TABLE[r].value, DIR_TABLE[r].is_last, DIR_TABLE[r].typed,
                   DIR_TABLE[r].pair_count, DIR_TABLE[r].overflowed);
        if ($urandom_range(0, 2) == 0) pause(gap_cycles());
      end
    end

    // random sets, k changes every four sets, one set overruns the store
    set_idx = 0;
    while (items_sent < ITEM_GOAL || sets_done < SET_GOAL) begin
      if (set_idx % 4 == 0) begin
        case ((set_idx / 4) % 7)
          0:       next_k = 32'($urandom_range(0, 8)) - 32'sd4;
          1:       next_k = $urandom;
          2:       next_k = VAL_MAX;
          3:       next_k = VAL_MIN;
          4:       next_k = 32'sd0;
          5:       next_k = 32'($urandom_range(1, 1000));
          default: next_k = -32'($urandom_range(1, 1000));
        endcase
        set_k(next_k);
      end
      if (set_idx == 15)
        set_len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
      else if ($urandom_range(0, 9) == 0)
        set_len = $urandom_range(17, 40);
      else
        set_len = $urandom_range(1, 16);
      if ($urandom_range(0, 3) == 0)
        base = VAL_MAX - 32'($urandom_range(0, 8));
      else
        base = $urandom;
      quiet = ($urandom_range(0, 3) == 0);
      for (int unsigned n = 0; n < set_len; n++) begin
        send_value(random_value(base), n == set_len - 1, 1'b0, '0, 1'b0);
        if (!quiet && $urandom_range(0, 3) == 0) pause(gap_cycles());
      end
      set_idx++;
    end

    // drain, then watch for stray results
    pause(1);
    while (pending_counts.size() != 0) @(negedge clk_i);
    repeat (2 * STORE_DEPTH + 16) @(posedge clk_i);

    $display("Sent %0d values in %0d sets (%0d past the store limit), %0d k_diff writes,",
             items_sent, sets_done, ovf_sets, k_writes);
    $display("checked %0d counts, long output hold-off done: %0b, mismatches: %0d",
             results_seen, pressure_done, fail_count);
    if (fail_count == 0 && pending_counts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
